FILE: rtl/sop_pkg.sv
`default_nettype none
package sop_pkg;

    localparam int SQRT_STAGES = 34;
    localparam int DIV_STAGES  = 34;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic        [30:0] a_radius;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic        [30:0] b_radius;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] pushed_x;
        logic signed [31:0] pushed_y;
        logic signed [31:0] pushed_z;
    } t_out;

    // per item data that rides alongside the arithmetic
    typedef struct packed {
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [2:0][32:0] mag;
        logic [2:0]       neg;
        logic [31:0]      r;
        logic             hit;
        logic [33:0]      len;
    } t_side;

    typedef struct packed {
        logic [34:0] rem;
        logic [33:0] root;
    } t_sq_step;

    typedef struct packed {
        logic [33:0] rem;
        logic        qbit;
    } t_div_step;

    function automatic t_sq_step sqrt_step(input logic [34:0] rem, input logic [33:0] root,
                                           input logic [1:0] pair);
        logic [36:0] cur;
        logic [36:0] trial;
        t_sq_step    res;
        cur   = {rem, pair};
        trial = {1'b0, root, 2'b01};
        if (cur >= trial) begin
            res.rem  = 35'(cur - trial);
            res.root = {root[32:0], 1'b1};
        end else begin
            res.rem  = cur[34:0];
            res.root = {root[32:0], 1'b0};
        end
        return res;
    endfunction

    function automatic t_div_step div_step(input logic [33:0] rem, input logic [33:0] len,
                                           input logic nbit);
        logic [34:0] cur;
        t_div_step   res;
        cur = {rem, nbit};
        if (cur >= {1'b0, len}) begin
            res.rem  = 34'(cur - {1'b0, len});
            res.qbit = 1'b1;
        end else begin
            res.rem  = cur[33:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [33:0] q,
                                            input logic neg);
        logic signed [35:0] sum;
        logic signed [35:0] off;
        off = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        sum = $signed({{4{a[31]}}, a}) + off;
        if (sum > 36'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (sum < -36'sd2147483648) begin
            return 32'h8000_0000;
        end
        return sum[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sop_if.sv
`default_nettype none
interface sop_in_if;
    logic          valid;
    logic          ready;
    sop_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sop_out_if;
    logic          valid;
    logic          ready;
    sop_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/sop_front.sv
`default_nettype none
module sop_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire sop_pkg::t_in  i_data,
    output logic               o_valid,
    output logic [65:0]        o_sum,
    output sop_pkg::t_side     o_side
);
    import sop_pkg::*;

    logic [2:0]  r_valid;
    t_side       r_side1, r_side2, r_side3;
    logic [2:0][65:0] r_sq;
    logic [63:0] r_rr;
    logic [65:0] r_sum;

    t_side       n_side1;
    t_side       n_side3;
    logic [2:0][32:0] n_d;

    always_comb begin
        n_d[0] = 33'($signed(i_data.b_x) - $signed(i_data.a_x));
        n_d[1] = 33'($signed(i_data.b_y) - $signed(i_data.a_y));
        n_d[2] = 33'($signed(i_data.b_z) - $signed(i_data.a_z));
        n_side1      = '0;
        n_side1.a    = {i_data.a_z, i_data.a_y, i_data.a_x};
        n_side1.b    = {i_data.b_z, i_data.b_y, i_data.b_x};
        n_side1.r    = {1'b0, i_data.a_radius} + {1'b0, i_data.b_radius};
        for (int i = 0; i < 3; i++) begin
            n_side1.neg[i] = n_d[i][32];
            n_side1.mag[i] = n_d[i][32] ? 33'(-n_d[i]) : n_d[i];
        end
    end

    always_comb begin
        n_side3     = r_side2;
        n_side3.hit = (r_sq[0] + r_sq[1] + r_sq[2]) <= {2'b00, r_rr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
        if (i_en) begin
            r_side1 <= n_side1;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= 66'(r_side1.mag[i] * r_side1.mag[i]);
            end
            r_rr    <= r_side1.r * r_side1.r;
            r_side2 <= r_side1;
            r_sum   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_side3 <= n_side3;
        end
    end

    assign o_valid = r_valid[2];
    assign o_sum   = r_sum;
    assign o_side  = r_side3;
endmodule
`default_nettype wire

FILE: rtl/sop_sqrt.sv
`default_nettype none
module sop_sqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [65:0]   i_sum,
    input  wire sop_pkg::t_side i_side,
    output logic               o_valid,
    output sop_pkg::t_side     o_side
);
    import sop_pkg::*;

    logic [SQRT_STAGES-1:0] r_valid;
    logic [67:0]            r_s    [SQRT_STAGES];
    logic [34:0]            r_rem  [SQRT_STAGES];
    logic [33:0]            r_root [SQRT_STAGES];
    t_side                  r_side [SQRT_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[SQRT_STAGES-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        t_sq_step    n_step;
        logic [67:0] n_s;
        t_side       n_side;
        if (k == 0) begin : g_first
            always_comb begin
                n_s    = {2'b00, i_sum};
                n_side = i_side;
                n_step = sqrt_step('0, '0, n_s[67:66]);
            end
        end else begin : g_next
            always_comb begin
                n_s    = r_s[k-1];
                n_side = r_side[k-1];
                n_step = sqrt_step(r_rem[k-1], r_root[k-1],
                                   n_s[2*(SQRT_STAGES-1-k)+1 -: 2]);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k]    <= n_s;
                r_side[k] <= n_side;
                r_rem[k]  <= n_step.rem;
                r_root[k] <= n_step.root;
            end
        end
    end

    always_comb begin
        o_side     = r_side[SQRT_STAGES-1];
        o_side.len = r_root[SQRT_STAGES-1];
    end
    assign o_valid = r_valid[SQRT_STAGES-1];
endmodule
`default_nettype wire

FILE: rtl/sop_div.sv
`default_nettype none
module sop_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire sop_pkg::t_side i_side,
    output logic               o_valid,
    output logic [2:0][33:0]   o_quot,
    output sop_pkg::t_side     o_side
);
    import sop_pkg::*;

    localparam int NSTG = DIV_STAGES + 2;

    logic [NSTG-1:0]   r_valid;
    t_side             r_side [NSTG];
    logic [2:0][64:0]  r_prod;
    logic [2:0][64:0]  r_num  [DIV_STAGES+1];
    logic [2:0][33:0]  r_rem  [DIV_STAGES+1];
    logic [2:0][33:0]  r_quot [DIV_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NSTG-2:0], i_valid};
        end
        if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= 65'(i_side.mag[i] * i_side.r);
            end
            r_side[1] <= r_side[0];
            for (int i = 0; i < 3; i++) begin
                r_num[0][i]  <= r_prod[i] + 65'(r_side[0].len[33:1]);
                r_rem[0][i]  <= '0;
                r_quot[0][i] <= '0;
            end
        end
    end

    // first divide stage takes the numerator bits above the quotient range
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [2:0][33:0] n_rem;
        logic [2:0][33:0] n_quot;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                t_div_step st;
                logic [33:0] rin;
                rin = (k == 0) ? 34'(r_num[k][i][64:DIV_STAGES]) : r_rem[k][i];
                st  = div_step(rin, r_side[k+1].len, r_num[k][i][DIV_STAGES-1-k]);
                n_rem[i]  = st.rem;
                n_quot[i] = {r_quot[k][i][32:0], st.qbit};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1]  <= r_num[k];
                r_rem[k+1]  <= n_rem;
                r_quot[k+1] <= n_quot;
                r_side[k+2] <= r_side[k+1];
            end
        end
    end

    assign o_valid = r_valid[NSTG-1];
    assign o_quot  = r_quot[DIV_STAGES];
    assign o_side  = r_side[NSTG-1];
endmodule
`default_nettype wire

FILE: rtl/sphere_overlap_push_out.sv
// sphere overlap push-out
// i_item carries two spheres (centre and radius, fixed point); o_res returns
// one word for every accepted item: hit, and the new centre of sphere b.
// both channels use valid/ready; a word moves when both are high.
// one item per cycle is taken in steady state while o_res.ready is high.
// from acceptance to o_res.valid an item passes the offset, square and
// overlap-test stages, the one-bit-per-stage square root, scale product
// and rounding term, the one-bit-per-stage divider and output register.
// the whole pipeline advances together; when the receiver holds o_res.ready
// low with a word waiting, i_item.ready drops and every stage holds, so no
// word is lost or repeated. a bubble in the output register is filled even
// while ready is low.
// synchronous active-low reset clears all valid bits; no clearing pass.
`default_nettype none
module sphere_overlap_push_out (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sop_in_if.sink     i_item,
    sop_out_if.source  o_res
);
    import sop_pkg::*;

    logic             w_en;
    logic             w_f_valid, w_s_valid, w_d_valid;
    logic [65:0]      w_sum;
    t_side            w_f_side, w_s_side, w_d_side;
    logic [2:0][33:0] w_quot;
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;

    assign w_en         = !r_out_valid || o_res.ready;
    assign i_item.ready = w_en;

    sop_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(i_item.valid), .i_data(i_item.data),
        .o_valid(w_f_valid), .o_sum(w_sum), .o_side(w_f_side)
    );

    sop_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(w_f_valid), .i_sum(w_sum), .i_side(w_f_side),
        .o_valid(w_s_valid), .o_side(w_s_side)
    );

    sop_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(w_s_valid), .i_side(w_s_side),
        .o_valid(w_d_valid), .o_quot(w_quot), .o_side(w_d_side)
    );

    always_comb begin
        logic [2:0][31:0] p;
        for (int i = 0; i < 3; i++) begin
            if (!w_d_side.hit) begin
                p[i] = w_d_side.b[i];
            end else if (w_d_side.len == '0) begin
                p[i] = w_d_side.a[i];
            end else begin
                p[i] = sat_add(w_d_side.a[i], w_quot[i], w_d_side.neg[i]);
            end
        end
        n_out.hit      = w_d_side.hit;
        n_out.pushed_x = p[0];
        n_out.pushed_y = p[1];
        n_out.pushed_z = p[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_item.ready)
        else $error("input taken while output stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("output valid right after reset");

    a_coincident_lands_on_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_d_valid && w_d_side.hit && w_d_side.len == '0)
        |=> (o_res.data.pushed_x == $past(w_d_side.a[0])))
        else $error("coincident centres not placed on a");

    a_miss_passes_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_d_valid && !w_d_side.hit)
        |=> (o_res.data.pushed_y == $past(w_d_side.b[1]) && !o_res.data.hit))
        else $error("miss does not pass b through");
endmodule
`default_nettype wire
